// ===== hdl/acdw_pkg.sv =====
`timescale 1ns / 1ps
package acdw_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_MAX_QUERY_GAP = 2'd0;
  localparam logic [1:0] REG_BAND_WIDTH    = 2'd1;
  localparam logic [1:0] REG_GAP_COEF      = 2'd2;

  localparam logic [30:0] MAX_QUERY_GAP_RST = 31'd5000;
  localparam logic [30:0] BAND_WIDTH_RST    = 31'd500;
  localparam logic [23:0] GAP_COEF_RST      = 24'd9830;

  // One stored anchor of the window.
  typedef struct packed {
    logic [31:0] ref_pos;
    logic [31:0] query_pos;
    logic [31:0] score;
    logic [31:0] peak;
  } entry_t;

  // Running best candidate handed from cell to cell.
  typedef struct packed {
    logic [31:0] score;
    logic [31:0] peak;
  } best_t;

  // Anchor under evaluation and the scoring limits, shared by all cells.
  typedef struct packed {
    logic [31:0] ref_pos;
    logic [31:0] query_pos;
    logic [7:0]  span_len;
    logic [30:0] max_query_gap;
    logic [30:0] band_width;
    logic [23:0] gap_coef;
  } anchor_t;

  // Half of the floor log2 of a nonzero value, zero for zero.
  function automatic logic [3:0] half_log2(input logic [30:0] v);
    logic [4:0] pos;
    pos = 5'd0;
    for (int i = 1; i < 31; i++) begin
      if (v[i]) pos = 5'(i);
    end
    return pos[4:1];
  endfunction

endpackage

// ===== hdl/acdw_cell.sv =====
`timescale 1ns / 1ps
module acdw_cell #(
  parameter int K  = 0,
  parameter int DW = 7
) (
  input  logic                clk_i,
  input  logic                shift_i,
  input  logic                valid_i,
  input  acdw_pkg::anchor_t   anchor_i,
  input  acdw_pkg::entry_t    entry_i,
  output acdw_pkg::entry_t    entry_o,
  input  acdw_pkg::best_t     best_i,
  input  logic [DW-1:0]       dist_i,
  output acdw_pkg::best_t     best_o,
  output logic [DW-1:0]       dist_o
);
  import acdw_pkg::*;

  entry_t             entry_q;
  logic               pass_a_q, pass_b_q, pass_c_q;
  logic [31:0]        alpha_a_q, alpha_b_q;
  logic [30:0]        dd_a_q;
  logic [3:0]         lg_a_q, lg_b_q;
  logic [31:0]        lin_b_q;
  logic [31:0]        cand_c_q;
  best_t              best_q;
  logic [DW-1:0]      dist_q;

  logic [31:0] dr, dq, mn, alpha;
  logic [32:0] diff, dd;
  logic        pass;
  logic [54:0] prod;

  // Window entry moves one cell deeper on each write-back.
  always_ff @(posedge clk_i) begin
    if (shift_i) entry_q <= entry_i;
  end
  assign entry_o = entry_q;

  // Stage A: gaps, gating tests and the span term.
  always_comb begin
    dr   = anchor_i.ref_pos - entry_q.ref_pos;
    dq   = anchor_i.query_pos - entry_q.query_pos;
    diff = {dr[31], dr} - {dq[31], dq};
    dd   = diff[32] ? (33'd0 - diff) : diff;
    pass = valid_i && (dr != 32'd0) && !dq[31] && (dq != 32'd0) &&
           (dq[30:0] <= anchor_i.max_query_gap) &&
           (dd[32:31] == 2'b00) && (dd[30:0] <= anchor_i.band_width);
    mn    = ($signed(dq) < $signed(dr)) ? dq : dr;
    alpha = ($signed(mn) > $signed({24'd0, anchor_i.span_len})) ?
            {24'd0, anchor_i.span_len} : mn;
  end

  always_ff @(posedge clk_i) begin
    pass_a_q  <= pass;
    alpha_a_q <= alpha;
    dd_a_q    <= dd[30:0];
    lg_a_q    <= half_log2(dd[30:0]);
  end

  // Stage B: linear gap cost, the gap times a coefficient in 8.16 fixed point.
  assign prod = 55'(dd_a_q) * 55'(anchor_i.gap_coef);

  always_ff @(posedge clk_i) begin
    pass_b_q  <= pass_a_q;
    alpha_b_q <= alpha_a_q;
    lg_b_q    <= lg_a_q;
    lin_b_q   <= prod[47:16];
  end

  // Stage C: candidate chain score, wrapping at 32 bits.
  always_ff @(posedge clk_i) begin
    pass_c_q <= pass_b_q;
    cand_c_q <= alpha_b_q - lin_b_q - {28'd0, lg_b_q} + entry_q.score;
  end

  // Best so far moves along the row; a tie keeps the nearer predecessor.
  always_ff @(posedge clk_i) begin
    if (pass_c_q && ($signed(cand_c_q) > $signed(best_i.score))) begin
      best_q.score <= cand_c_q;
      best_q.peak  <= entry_q.peak;
      dist_q       <= DW'(K + 1);
    end else begin
      best_q <= best_i;
      dist_q <= dist_i;
    end
  end
  assign best_o = best_q;
  assign dist_o = dist_q;

endmodule

// ===== hdl/anchor_chain_dp_window.sv =====
`timescale 1ns / 1ps
// Anchor chaining over a window of the last WINDOW_DEPTH anchors.
// Input items arrive on the s_axis group: tdata carries ref_pos, query_pos
// and span_len, tuser carries start_of_set, which empties the window and
// restarts the set index before the item is scored. Each item gives one
// result item on m_axis: chain_score, parent_index (-1 for none) and
// peak_score. Limits are written through cfg_we_i / cfg_idx_i / cfg_data_i.
// One cell per window entry scores its stored anchor in a three stage
// pipeline (gaps and tests, gap-cost multiply, sum). The running best then
// travels down the row of cells one cell per cycle, and one item is in
// work at a time: the next item is not accepted until the last one is
// written back, once its best has swept the whole row.
// The result sits in an output register; the next item is accepted while
// it waits, but write-back of that item waits until the receiver takes it.
// Reset empties the window, zeroes the set index and restores the register
// defaults. No clearing pass is needed.
module anchor_chain_dp_window #(
  parameter int WINDOW_DEPTH = 64,
  parameter int INDEX_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // ref_pos, query_pos, span_len
  input  logic        s_axis_tuser,  // start_of_set
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // chain_score, parent_index, peak_score
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i
);
  import acdw_pkg::*;

  localparam int DW   = $clog2(WINDOW_DEPTH + 1);
  localparam int LAT  = WINDOW_DEPTH + 3;
  localparam int CW   = $clog2(LAT + 1);
  localparam int IDXW = (INDEX_BITS > 32) ? INDEX_BITS : 32;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic                  state_q, state_d;
  logic [CW-1:0]         cnt_q;
  logic [DW-1:0]         fill_q;
  logic [INDEX_BITS-1:0] ctr_q;
  logic [30:0]           mqg_q, bw_q;
  logic [23:0]           coef_q;
  logic [31:0]           ref_q, qry_q;
  logic [7:0]            span_q;
  logic                  out_vld_q;
  logic [95:0]           out_q;

  anchor_t       anchor;
  entry_t        entries [WINDOW_DEPTH+1];
  best_t         bests   [WINDOW_DEPTH+1];
  logic [DW-1:0] dists   [WINDOW_DEPTH+1];
  logic          accept, wr;
  best_t         fin;
  logic [DW-1:0] fin_dist;
  logic [31:0]   res_score, res_peak, res_parent;
  logic [INDEX_BITS-1:0] par;
  logic [IDXW-1:0]       par_ext;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign wr = (state_q == ST_BUSY) && (cnt_q == CW'(LAT)) &&
              (!out_vld_q || m_axis_tready);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mqg_q  <= MAX_QUERY_GAP_RST;
      bw_q   <= BAND_WIDTH_RST;
      coef_q <= GAP_COEF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_QUERY_GAP: mqg_q  <= cfg_data_i;
        REG_BAND_WIDTH:    bw_q   <= cfg_data_i;
        REG_GAP_COEF:      coef_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // Sequencer: accept, wait for scoring and the sweep, write back.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_BUSY;
      ST_BUSY: if (wr) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      fill_q  <= '0;
      ctr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
        if (s_axis_tuser) begin
          fill_q <= '0;
          ctr_q  <= '0;
        end
      end else if (state_q == ST_BUSY && cnt_q != CW'(LAT)) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (wr) begin
        if (fill_q != DW'(WINDOW_DEPTH)) fill_q <= fill_q + 1'b1;
        ctr_q <= ctr_q + 1'b1;
      end
    end
  end

  // Anchor under evaluation.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ref_q  <= s_axis_tdata[31:0];
      qry_q  <= s_axis_tdata[63:32];
      span_q <= s_axis_tdata[71:64];
    end
  end

  assign anchor = '{ref_pos: ref_q, query_pos: qry_q, span_len: span_q,
                    max_query_gap: mqg_q, band_width: bw_q, gap_coef: coef_q};

  // Row of cells; the new entry enters at the nearest end.
  assign fin_dist = dists[WINDOW_DEPTH];
  assign fin      = bests[WINDOW_DEPTH];
  assign res_score = fin.score;
  assign res_peak  = ((fin_dist != '0) && ($signed(fin.peak) > $signed(fin.score))) ?
                     fin.peak : fin.score;

  assign entries[0] = '{ref_pos: ref_q, query_pos: qry_q, score: res_score,
                        peak: res_peak};
  assign bests[0]   = '{score: {24'd0, span_q}, peak: {24'd0, span_q}};
  assign dists[0]   = '0;

  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    acdw_cell #(.K(k), .DW(DW)) u_cell (
      .clk_i    (clk_i),
      .shift_i  (wr),
      .valid_i  (DW'(k) < fill_q),
      .anchor_i (anchor),
      .entry_i  (entries[k]),
      .entry_o  (entries[k+1]),
      .best_i   (bests[k]),
      .dist_i   (dists[k]),
      .best_o   (bests[k+1]),
      .dist_o   (dists[k+1])
    );
  end

  // Parent index within the set.
  assign par        = ctr_q - INDEX_BITS'(fin_dist);
  assign par_ext    = IDXW'(par);
  assign res_parent = (fin_dist == '0) ? 32'hFFFF_FFFF : par_ext[31:0];

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (wr) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) out_q <= {res_peak, res_parent, res_score};
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // Checks.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DW'(WINDOW_DEPTH))
    else $error("window fill beyond depth");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(LAT))
    else $error("sequencer count out of range");
  a_wr_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr |=> fill_q != '0)
    else $error("window empty after write-back");
  a_wr_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr |=> m_axis_tvalid && s_axis_tready)
    else $error("result not presented after write-back");
  a_no_parent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && fin_dist == '0) |=> m_axis_tdata[63:32] == 32'hFFFF_FFFF)
    else $error("missing none marker for parentless result");

endmodule
